FILE: hw/rtl/sml_pkg.sv
// Shared types, constants and register codes for the struct member layout block.
// Used by sml_rem, sml_core and struct_member_layout; depends on nothing.
`default_nettype none

package sml_pkg;

  // Default width of byte offsets and sizes; the bit cursor is three bits wider.
  localparam int OFFSET_BITS_DEF = 24;

  // Fixed field widths of one member word and one result word.
  localparam int SIZE_W   = 20;
  localparam int ALIGN_W  = 9;
  localparam int FBITS_W  = 7;
  localparam int OFF_W    = 24;
  localparam int BOFF_W   = 6;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 64;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNION     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALIGN = 2'd2;

  typedef struct packed {
    logic               packed_mode;
    logic               union_mode;
    logic [ALIGN_W-1:0] struct_min_align;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  member_size;
    logic [ALIGN_W-1:0] member_natural_align;
    logic [ALIGN_W-1:0] member_explicit_align;
    logic               is_bit_field;
    logic [FBITS_W-1:0] field_bits;
    logic               last_member;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]   byte_offset;
    logic [BOFF_W-1:0]  bit_offset;
    logic [OFF_W-1:0]   total_size;
    logic [ALIGN_W-1:0] struct_align;
    logic               layout_done;
    logic               overflow;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sml_rem.sv
// Bit-serial remainder unit: cursor byte position modulo the bitfield type size.
// One dividend bit per cycle; depends on sml_pkg.
`default_nettype none

module sml_rem
  import sml_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   clear_i,
  input  wire logic [OFFSET_BITS-1:0] dividend_i,
  input  wire logic [SIZE_W-1:0]      divisor_i,
  output rem_stat_t                   status_o,
  output logic [SIZE_W-1:0]           rem_o
);

  localparam int CNTW = $clog2(OFFSET_BITS + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [SIZE_W-1:0]      rem_q, rem_d;
  logic [OFFSET_BITS-1:0] dvd_q, dvd_d;
  logic [SIZE_W:0]        trial;

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[OFFSET_BITS-1]};
    if (clear_i) begin
      done_d = 1'b0;
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNTW'(OFFSET_BITS);
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      // Restoring step: the partial remainder stays below the divisor.
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = SIZE_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[SIZE_W-1:0];
      end
      dvd_d = {dvd_q[OFFSET_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sml_core.sv
// Layout step for one member plus the running cursor, union extent and alignment.
// Depends on sml_pkg; the remainder for non-power-of-two bitfield units comes from sml_rem.
`default_nettype none

module sml_core
  import sml_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   fire_i,
  input  wire in_item_t               item_i,
  input  wire cfg_t                   cfg_i,
  input  wire logic [SIZE_W-1:0]      rem_i,
  output res_t                        res_o,
  output logic                        mod_slow_o,
  output logic [OFFSET_BITS-1:0]      cur_bytes_o
);

  localparam int W  = OFFSET_BITS;
  localparam int CW = W + 3;
  localparam int AW = ((CW > 23) ? CW : 23) + 1;
  localparam int UW = ((W > SIZE_W) ? W : SIZE_W) + 1;
  localparam int RW = W + 2;
  localparam logic [W-1:0]  OFF_MAX = '1;
  localparam logic [CW-1:0] CUR_MAX = '1;

  logic [CW-1:0]      cursor_q, cursor_d;
  logic [W-1:0]       extent_q, extent_d;
  logic [ALIGN_W-1:0] ralign_q, ralign_d;
  logic               ovf_q, ovf_d;

  logic [ALIGN_W-1:0] nat_a, mem_align, salign;
  logic               unit_nz, size_pow2, need_mod, ovf_n;
  logic [SIZE_W-1:0]  rem_b;
  logic [AW-1:0]      cur_a, unit_a, r0_a, base_a, up_a, cur1_a, start_a, boff_a, next_a;
  logic [SIZE_W-1:0]  ext;
  logic [7:0]         ext_bits;
  logic [W-1:0]       ext_s, off;
  logic [CW:0]        cur7;
  logic [RW-1:0]      bpos, mam1, rnd, bytes, sam1, tot_r;
  logic [UW-1:0]      endpos;
  logic [CW:0]        curn7;
  logic [BOFF_W-1:0]  boff;
  logic [W-1:0]       total;

  always_comb begin
    cursor_d  = cursor_q;
    extent_d  = extent_q;
    off       = '0;
    boff      = '0;
    ovf_n     = 1'b0;
    ext       = '0;
    ext_bits  = '0;
    ext_s     = '0;
    cur7      = '0;
    bpos      = '0;
    rnd       = '0;
    endpos    = '0;
    cur1_a    = '0;
    start_a   = '0;
    boff_a    = '0;
    next_a    = '0;
    total     = '0;
    salign    = ALIGN_W'(1);
    bytes     = '0;
    sam1      = '0;
    tot_r     = '0;
    curn7     = '0;

    nat_a     = (item_i.member_natural_align == '0) ? ALIGN_W'(1) : item_i.member_natural_align;
    mem_align = cfg_i.packed_mode ? ALIGN_W'(1) : nat_a;
    if (item_i.member_explicit_align > mem_align) begin
      mem_align = item_i.member_explicit_align;
    end
    mam1 = RW'(mem_align) - RW'(1);

    unit_nz   = (item_i.member_size != '0);
    size_pow2 = unit_nz && ((item_i.member_size & (item_i.member_size - SIZE_W'(1))) == '0);
    need_mod  = !cfg_i.union_mode && item_i.is_bit_field && unit_nz &&
                !(item_i.field_bits == '0 && cfg_i.packed_mode);

    // Byte remainder of the cursor: a mask for power-of-two units, else the serial unit.
    if (size_pow2) begin
      rem_b = SIZE_W'(cursor_q[CW-1:3] & W'(item_i.member_size - SIZE_W'(1)));
    end else begin
      rem_b = rem_i;
    end

    cur_a  = AW'(cursor_q);
    unit_a = AW'({item_i.member_size, 3'b000});
    r0_a   = AW'({rem_b, cursor_q[2:0]});
    base_a = cur_a - r0_a;
    up_a   = base_a + unit_a;

    if (cfg_i.union_mode) begin
      ext_bits = ({1'b0, item_i.field_bits} + 8'd7) >> 3;
      ext      = item_i.is_bit_field ? SIZE_W'(ext_bits) : item_i.member_size;
      if (UW'(ext) > UW'(OFF_MAX)) begin
        ext_s = OFF_MAX;
        ovf_n = 1'b1;
      end else begin
        ext_s = W'(ext);
      end
      if (ext_s > extent_q) begin
        extent_d = ext_s;
      end
    end else if (item_i.is_bit_field) begin
      if (item_i.field_bits == '0) begin
        cur1_a = cur_a;
        if (!cfg_i.packed_mode && unit_nz && r0_a != '0) begin
          if (up_a > AW'(CUR_MAX)) begin
            cur1_a = AW'(CUR_MAX);
            ovf_n  = 1'b1;
          end else begin
            cur1_a = up_a;
          end
        end
        off      = cur1_a[CW-1:3];
        cursor_d = cur1_a[CW-1:0];
      end else begin
        if (unit_nz) begin
          cur1_a  = cur_a;
          start_a = base_a;
          boff_a  = r0_a;
          // The field would straddle a unit: move to the next unit start.
          if (!cfg_i.packed_mode && (r0_a + AW'(item_i.field_bits) > unit_a) &&
              r0_a != '0) begin
            if (up_a > AW'(CUR_MAX)) begin
              cur1_a = AW'(CUR_MAX);
              boff_a = AW'(CUR_MAX) - base_a;
              ovf_n  = 1'b1;
            end else begin
              cur1_a  = up_a;
              start_a = up_a;
              boff_a  = '0;
            end
          end
          off = start_a[CW-1:3];
        end else begin
          cur1_a = cur_a;
          off    = cursor_q[CW-1:3];
          boff_a = AW'(cursor_q[2:0]);
        end
        next_a = cur1_a + AW'(item_i.field_bits);
        if (next_a > AW'(CUR_MAX)) begin
          cursor_d = CUR_MAX;
          ovf_n    = 1'b1;
        end else begin
          cursor_d = next_a[CW-1:0];
        end
        if (boff_a > AW'(63)) begin
          boff  = '1;
          ovf_n = 1'b1;
        end else begin
          boff = boff_a[BOFF_W-1:0];
        end
      end
    end else begin
      cur7 = {1'b0, cursor_q} + (CW+1)'(7);
      bpos = RW'(cur7[CW:3]);
      rnd  = (bpos + mam1) & ~mam1;
      if (rnd > RW'(OFF_MAX)) begin
        off   = OFF_MAX;
        ovf_n = 1'b1;
      end else begin
        off = rnd[W-1:0];
      end
      endpos = UW'(off) + UW'(item_i.member_size);
      if (endpos > UW'(OFF_MAX)) begin
        cursor_d = CUR_MAX;
        ovf_n    = 1'b1;
      end else begin
        cursor_d = {endpos[W-1:0], 3'b000};
      end
    end

    ralign_d = (mem_align > ralign_q) ? mem_align : ralign_q;

    if (item_i.last_member) begin
      salign = (cfg_i.struct_min_align > ralign_d) ? cfg_i.struct_min_align : ralign_d;
      curn7  = {1'b0, cursor_d} + (CW+1)'(7);
      bytes  = cfg_i.union_mode ? RW'(extent_d) : RW'(curn7[CW:3]);
      sam1   = RW'(salign) - RW'(1);
      tot_r  = (bytes + sam1) & ~sam1;
      if (tot_r > RW'(OFF_MAX)) begin
        total = OFF_MAX;
        ovf_n = 1'b1;
      end else begin
        total = tot_r[W-1:0];
      end
    end

    ovf_d = ovf_q | ovf_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      extent_q <= '0;
      ralign_q <= ALIGN_W'(1);
      ovf_q    <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last_member) begin
        cursor_q <= '0;
        extent_q <= '0;
        ralign_q <= ALIGN_W'(1);
        ovf_q    <= 1'b0;
      end else begin
        cursor_q <= cursor_d;
        extent_q <= extent_d;
        ralign_q <= ralign_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  assign res_o.byte_offset  = OFF_W'(off);
  assign res_o.bit_offset   = boff;
  assign res_o.total_size   = OFF_W'(total);
  assign res_o.struct_align = salign;
  assign res_o.layout_done  = item_i.last_member;
  assign res_o.overflow     = ovf_d;
  assign mod_slow_o         = need_mod && !size_pow2;
  assign cur_bytes_o        = cursor_q[CW-1:3];

endmodule

`default_nettype wire

FILE: hw/rtl/struct_member_layout.sv
// An accepted member word waits in the input register until it fires into the result register.
// A bitfield whose declared type size is not a power of two also waits there for the bit-serial
// remainder unit; all other members go through at one per cycle while the output does not stall.
// A held result stalls intake once the input register is full, until the held result is taken.
// Reset (rst_ni low, asynchronous) clears the configuration, the layout state and all valids.
`default_nettype none

module struct_member_layout
  import sml_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ALIGN_W-1:0]   cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // member_size, member_natural_align, member_explicit_align, field_bits, zero fill
  input  wire logic [IN_DW-1:0]     s_axis_tdata,
  // is_bit_field
  input  wire logic                 s_axis_tuser,
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // byte_offset, bit_offset, total_size, struct_align, zero fill
  output logic [OUT_DW-1:0]         m_axis_tdata,
  // overflow
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  cfg_t      cfg_q;
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  res_t      out_q;
  res_t      res;
  logic      fire, rem_ok, mod_slow, rem_start;
  rem_stat_t rem_stat;
  logic [SIZE_W-1:0]      rem_val;
  logic [OFFSET_BITS-1:0] cur_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PACKED:    cfg_q.packed_mode      <= cfg_data_i[0];
        CFG_UNION:     cfg_q.union_mode       <= cfg_data_i[0];
        CFG_MIN_ALIGN: cfg_q.struct_min_align <= cfg_data_i;
        default:       cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign rem_ok        = !mod_slow || rem_stat.done;
  assign fire          = in_vld_q && rem_ok && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign rem_start     = in_vld_q && mod_slow && !rem_stat.busy && !rem_stat.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.member_size           <= s_axis_tdata[19:0];
      in_q.member_natural_align  <= s_axis_tdata[28:20];
      in_q.member_explicit_align <= s_axis_tdata[37:29];
      in_q.field_bits            <= s_axis_tdata[44:38];
      in_q.is_bit_field          <= s_axis_tuser;
      in_q.last_member           <= s_axis_tlast;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  sml_rem #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .clear_i    (fire),
    .dividend_i (cur_bytes),
    .divisor_i  (in_q.member_size),
    .status_o   (rem_stat),
    .rem_o      (rem_val)
  );

  sml_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .rem_i       (rem_val),
    .res_o       (res),
    .mod_slow_o  (mod_slow),
    .cur_bytes_o (cur_bytes)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.struct_align, out_q.total_size,
                          out_q.bit_offset, out_q.byte_offset};
  assign m_axis_tuser  = out_q.overflow;
  assign m_axis_tlast  = out_q.layout_done;

  a_rem_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rem_stat.busy && rem_stat.done))
    else $error("remainder unit busy and done together");

  a_fire_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("computed result did not reach the output register");

  a_rem_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_stat.busy |-> (in_vld_q && mod_slow))
    else $error("remainder unit running without a waiting bitfield word");

  a_slow_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && mod_slow && !rem_stat.done) |-> !fire)
    else $error("bitfield word advanced before its remainder was ready");

endmodule

`default_nettype wire

FILE: sim/tb_struct_member_layout.sv
// Self-checking testbench for struct_member_layout: drives member words on the slave stream,
// predicts each placement result in SystemVerilog or takes the fixed result of a directed row,
// and checks the master stream word by word. Depends on sml_pkg and struct_member_layout only.
`timescale 1ns / 100ps

module tb_struct_member_layout;
  import sml_pkg::*;

  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 146;
  localparam int SETTLE_CYCLES   = OFFSET_BITS_DEF + 8;
  localparam int WD_LIMIT        = 4000;
  localparam longint unsigned BYTES_MAX  = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
  localparam longint unsigned CURSOR_MAX = (64'd1 << (OFFSET_BITS_DEF + 3)) - 64'd1;

  typedef struct packed {
    logic     reconfig;
    cfg_t     cfg;
    in_item_t mem;
    logic     fixed;
    res_t     want;
  } row_t;

  typedef struct packed {
    logic fixed;
    res_t want;
  } pinned_t;

  localparam cfg_t C0 = '{1'b0, 1'b0, 9'd0};
  localparam cfg_t CP = '{1'b1, 1'b0, 9'd0};
  localparam cfg_t CU = '{1'b0, 1'b1, 9'd256};

  // Each row: reconfigure first?, settings, member, fixed result given?, fixed result.
  localparam row_t DIRECTED [23] = '{
    '{0, C0, '{1, 1, 0, 0, 0, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, C0, '{4, 4, 0, 0, 0, 1},         1, '{4, 0, 8, 4, 1, 0}},
    '{0, C0, '{4, 4, 0, 1, 3, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, C0, '{4, 4, 0, 1, 30, 0},        1, '{4, 0, 0, 1, 0, 0}},
    '{0, C0, '{4, 4, 0, 1, 0, 0},         1, '{8, 0, 0, 1, 0, 0}},
    '{0, C0, '{4, 4, 0, 1, 64, 1},        1, '{8, 0, 16, 4, 1, 0}},
    '{0, C0, '{0, 1, 0, 1, 5, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, C0, '{0, 1, 0, 1, 7, 0},         1, '{0, 5, 0, 1, 0, 0}},
    '{0, C0, '{16, 16, 0, 1, 127, 1},     1, '{16, 0, 32, 16, 1, 0}},
    '{0, C0, '{16, 1, 0, 1, 70, 0},       1, '{0, 0, 0, 1, 0, 0}},
    '{0, C0, '{16, 1, 0, 1, 10, 1},       1, '{0, 63, 10, 1, 1, 1}},
    '{0, C0, '{1, 1, 0, 0, 0, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, C0, '{2, 3, 0, 0, 0, 1},         0, '0},
    '{0, C0, '{4, 0, 0, 0, 0, 1},         1, '{0, 0, 4, 1, 1, 0}},
    '{0, C0, '{1, 1, 256, 0, 0, 1},       1, '{0, 0, 256, 256, 1, 0}},
    '{1, CP, '{1, 1, 0, 0, 0, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, CP, '{4, 4, 0, 0, 0, 0},         0, '0},
    '{0, CP, '{4, 4, 0, 1, 30, 0},        0, '0},
    '{0, CP, '{4, 4, 0, 1, 0, 1},         0, '0},
    '{1, CU, '{3, 2, 0, 0, 0, 0},         1, '{0, 0, 0, 1, 0, 0}},
    '{0, CU, '{4, 4, 0, 1, 17, 0},        1, '{0, 0, 0, 1, 0, 0}},
    '{0, CU, '{1048575, 1, 0, 0, 0, 1},   1, '{0, 0, 1048576, 256, 1, 0}},
    '{1, C0, '{0, 256, 0, 0, 0, 1},       1, '{0, 0, 0, 256, 1, 0}}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ALIGN_W-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_DW-1:0]     s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]    m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  int send_idle_pct = 37;
  int recv_idle_pct = 59;
  int mismatch_cnt  = 0;
  int idle_cycles   = 0;

  // Mirror of the configuration registers and of the running layout state.
  logic            sh_packed = 1'b0;
  logic            sh_union  = 1'b0;
  longint unsigned sh_min_align = 0;
  longint unsigned cur_bits    = 0;
  longint unsigned union_bytes = 0;
  longint unsigned run_align   = 1;
  logic            ovf_sticky  = 1'b0;

  res_t    layout_q[$];
  pinned_t pinned_q[$];

  struct_member_layout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic longint unsigned round_up(longint unsigned x, longint unsigned a);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  function automatic longint unsigned clamp_bits(longint unsigned v);
    if (v > CURSOR_MAX) begin
      ovf_sticky = 1'b1;
      return CURSOR_MAX;
    end
    return v;
  endfunction

  function automatic longint unsigned clamp_bytes(longint unsigned v);
    if (v > BYTES_MAX) begin
      ovf_sticky = 1'b1;
      return BYTES_MAX;
    end
    return v;
  endfunction

  // Places one member and advances the running layout state.
  function automatic res_t layout_member(in_item_t m);
    longint unsigned sz, nat, bw, ma, off, boff, tot, salign, unit, cur, q, ext, bytes;
    res_t r;
    sz     = m.member_size;
    nat    = m.member_natural_align;
    bw     = m.field_bits;
    off    = 0;
    boff   = 0;
    tot    = 0;
    salign = 1;
    if (nat == 0) nat = 1;
    ma = sh_packed ? 64'd1 : nat;
    if (m.member_explicit_align > ma) ma = m.member_explicit_align;

    if (sh_union) begin
      ext = m.is_bit_field ? (bw + 64'd7) >> 3 : sz;
      ext = clamp_bytes(ext);
      if (ext > union_bytes) union_bytes = ext;
    end else if (m.is_bit_field) begin
      unit = sz * 64'd8;
      cur  = cur_bits;
      if (bw == 0) begin
        // A zero-width field only closes the current storage unit.
        if (!sh_packed && unit != 0) cur = clamp_bits((cur + unit - 64'd1) / unit * unit);
        off = cur >> 3;
      end else begin
        if (!sh_packed && unit != 0 && cur / unit != (cur + bw - 64'd1) / unit) begin
          cur = clamp_bits((cur + unit - 64'd1) / unit * unit);
        end
        if (unit != 0) begin
          q    = cur / unit;
          off  = q * sz;
          boff = cur - q * unit;
        end else begin
          off  = cur >> 3;
          boff = cur & 64'd7;
        end
        cur = clamp_bits(cur + bw);
      end
      if (boff > 63) begin
        boff       = 63;
        ovf_sticky = 1'b1;
      end
      off      = clamp_bytes(off);
      cur_bits = cur;
    end else begin
      off      = clamp_bytes(round_up((cur_bits + 64'd7) >> 3, ma));
      cur_bits = clamp_bits((off + sz) * 64'd8);
    end

    if (ma > run_align) run_align = ma;

    if (m.last_member) begin
      salign = (sh_min_align > run_align) ? sh_min_align : run_align;
      bytes  = sh_union ? union_bytes : (cur_bits + 64'd7) >> 3;
      tot    = clamp_bytes(round_up(bytes, salign));
    end

    r.byte_offset  = OFF_W'(off);
    r.bit_offset   = BOFF_W'(boff);
    r.total_size   = OFF_W'(tot);
    r.struct_align = ALIGN_W'(salign);
    r.layout_done  = m.last_member;
    r.overflow     = ovf_sticky;

    if (m.last_member) begin
      cur_bits    = 0;
      union_bytes = 0;
      run_align   = 1;
      ovf_sticky  = 1'b0;
    end
    return r;
  endfunction

  function automatic in_item_t rand_member(bit last, bit bulky);
    in_item_t    m;
    int unsigned roll;
    int unsigned unit_bits;
    m = '0;
    m.last_member  = last;
    m.is_bit_field = !bulky && ($urandom_range(0, 99) < 45);
    roll = $urandom_range(0, 99);
    if (bulky) begin
      m.member_size = SIZE_W'($urandom_range(32'hC0000, 32'hFFFFF));
    end else if (m.is_bit_field) begin
      if (roll < 70)      m.member_size = SIZE_W'(1 << $urandom_range(0, 4));
      else if (roll < 85) m.member_size = SIZE_W'($urandom_range(3, 12));
      else if (roll < 93) m.member_size = '0;
      else                m.member_size = SIZE_W'($urandom());
    end else if (roll < 96) begin
      m.member_size = SIZE_W'($urandom_range(0, 64));
    end else begin
      m.member_size = SIZE_W'($urandom());
    end

    unit_bits = (m.member_size == 0 || m.member_size > 8) ? 64 : m.member_size * 8;
    roll = $urandom_range(0, 99);
    if (!m.is_bit_field || roll >= 92) m.field_bits = FBITS_W'($urandom());
    else if (roll < 8)                 m.field_bits = '0;
    else                               m.field_bits = FBITS_W'($urandom_range(1, unit_bits));

    roll = $urandom_range(0, 99);
    if (roll < 95) m.member_natural_align = ALIGN_W'(1 << $urandom_range(0, 8));
    else           m.member_natural_align = ALIGN_W'($urandom());

    roll = $urandom_range(0, 99);
    if (roll < 65)      m.member_explicit_align = '0;
    else if (roll < 97) m.member_explicit_align = ALIGN_W'(1 << $urandom_range(0, 8));
    else                m.member_explicit_align = ALIGN_W'($urandom());
    return m;
  endfunction

  task automatic log_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_member(in_item_t m, logic fixed, res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    pinned_q.push_back('{fixed, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, m.field_bits, m.member_explicit_align,
                      m.member_natural_align, m.member_size};
    s_axis_tuser  <= m.is_bit_field;
    s_axis_tlast  <= m.last_member;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic wait_layouts_drained();
    s_axis_tvalid <= 1'b0;
    while (layout_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle_and_configure(cfg_t c);
    wait_layouts_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PACKED;
    cfg_data_i <= ALIGN_W'(c.packed_mode);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_UNION;
    cfg_data_i <= ALIGN_W'(c.union_mode);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MIN_ALIGN;
    cfg_data_i <= c.struct_min_align;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  always @(posedge clk_i) begin : monitor
    in_item_t got;
    pinned_t  pin;
    res_t     res;
    res_t     due;
    logic     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PACKED:    sh_packed    = cfg_data_i[0];
          CFG_UNION:     sh_union     = cfg_data_i[0];
          CFG_MIN_ALIGN: sh_min_align = cfg_data_i;
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        got.member_size           = s_axis_tdata[19:0];
        got.member_natural_align  = s_axis_tdata[28:20];
        got.member_explicit_align = s_axis_tdata[37:29];
        got.field_bits            = s_axis_tdata[44:38];
        got.is_bit_field          = s_axis_tuser;
        got.last_member           = s_axis_tlast;
        pin = pinned_q.pop_front();
        res = layout_member(got);
        layout_q.push_back(pin.fixed ? pin.want : res);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (layout_q.size() == 0) begin
          log_mismatch("result word with no member outstanding");
        end else begin
          due = layout_q.pop_front();
          check_field("byte_offset", m_axis_tdata[23:0], due.byte_offset);
          check_field("bit_offset", m_axis_tdata[29:24], due.bit_offset);
          check_field("total_size", m_axis_tdata[53:30], due.total_size);
          check_field("struct_align", m_axis_tdata[62:54], due.struct_align);
          check_field("layout_done", m_axis_tlast, due.layout_done);
          check_field("overflow", m_axis_tuser, due.overflow);
        end
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("tb_struct_member_layout: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    int   sent;
    int   n;
    bit   bulky;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PACKED;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].reconfig) settle_and_configure(DIRECTED[i].cfg);
      send_member(DIRECTED[i].mem, DIRECTED[i].fixed, DIRECTED[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 37;
      end else if (ph == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      c.packed_mode = ph[0];
      c.union_mode  = (ph % 6 == 2) || (ph % 6 == 5);
      if (ph % 3 == 0)               c.struct_min_align = '0;
      else if (ph % 3 == 1)          c.struct_min_align = 9'd256;
      else if ($urandom_range(0, 3)) c.struct_min_align = ALIGN_W'(1 << $urandom_range(0, 8));
      else                           c.struct_min_align = ALIGN_W'($urandom_range(0, 256));
      settle_and_configure(c);

      sent  = 0;
      bulky = 1'b1;    // every phase opens with one struct of huge members
      while (sent < WORDS_PER_PHASE) begin
        n = bulky ? $urandom_range(14, 22) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          send_member(rand_member(k == n - 1, bulky), 1'b0, '0);
          sent++;
          if ($urandom_range(0, 59) == 0) wait_layouts_drained();
        end
        bulky = 1'b0;
      end
    end

    wait_layouts_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (layout_q.size() != 0) log_mismatch("results still outstanding at the end");
    if (mismatch_cnt == 0) begin
      $display("tb_struct_member_layout: PASS");
    end else begin
      $display("tb_struct_member_layout: FAIL");
    end
    $finish;
  end

endmodule
